/* design/tsbc_pkg.sv */
package tsbc_pkg;

  localparam int FOLD_PASSES    = 7;
  // fold passes done between two pipeline registers
  localparam int FOLD_PER_STAGE = 2;
  localparam int FOLD_STAGES    = (FOLD_PASSES + FOLD_PER_STAGE - 1) / FOLD_PER_STAGE;

  localparam logic signed [31:0] FOLD_CEIL  = 32'sd32767;
  localparam logic signed [31:0] FOLD_FLOOR = -32'sd32767;
  localparam logic signed [31:0] FOLD_SPAN  = 32'sd65534;
  localparam logic signed [31:0] MIX_BIAS   = 32'sd32768;
  localparam logic [15:0]        A5_OFFSET  = 16'h7fff;

  typedef enum logic [2:0] {
    MODE_OR      = 3'd0,
    MODE_PROD    = 3'd1,
    MODE_XOR     = 3'd2,
    MODE_AND     = 3'd3,
    MODE_MIX_MUL = 3'd4,
    MODE_MIX_SUM = 3'd5,
    MODE_MIX_OR  = 3'd6
  } combine_mode_e;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } pipe_t;

  function automatic logic signed [31:0] fold_pass(input logic signed [31:0] t);
    logic signed [31:0] r;
    r = t;
    if (r > FOLD_CEIL) r = FOLD_SPAN - r;
    if (r < FOLD_FLOOR) r = -FOLD_SPAN - r;
    return r;
  endfunction

endpackage

/* design/tsbc_if.sv */
interface tsbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_a;
  logic signed [15:0] sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

interface tsbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface tsbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] combine_mode;

  modport source (output valid, output combine_mode, input ready);
  modport sink   (input valid, input combine_mode, output ready);
endinterface

/* design/tsbc_combine.sv */
module tsbc_combine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic signed [15:0]     sample_a_i,
  input  logic signed [15:0]     sample_b_i,
  input  tsbc_pkg::combine_mode_e mode_i,
  output tsbc_pkg::pipe_t        res_o
);

  localparam logic [15:0] A5_OFFSET_L = tsbc_pkg::A5_OFFSET;

  // stage 1: byte products and the full product
  logic                    s1_vld_q;
  tsbc_pkg::combine_mode_e s1_mode_q;
  logic signed [15:0]      s1_a_q, s1_b_q;
  logic signed [31:0]      s1_prod_q, s1_prod_d;
  logic [15:0]             s1_p1_q, s1_p1_d, s1_p2_q, s1_p2_d;
  logic [15:0]             s1_q5a_q, s1_q5a_d, s1_q5b_q, s1_q5b_d;
  logic [15:0]             s1_q6_q, s1_q6_d;
  logic [15:0]             a5;

  always_comb begin
    a5        = sample_a_i + A5_OFFSET_L;
    s1_prod_d = 32'(sample_a_i) * 32'(sample_b_i);
    s1_p1_d   = {8'd0, sample_a_i[15:8]} * {8'd0, sample_b_i[7:0]};
    s1_p2_d   = {8'd0, sample_b_i[15:8]} * {8'd0, sample_a_i[7:0]};
    s1_q5a_d  = {8'd0, a5[15:8]} * {8'd0, a5[7:0]};
    s1_q5b_d  = {8'd0, sample_b_i[15:8]} * {8'd0, sample_b_i[7:0]};
    s1_q6_d   = {8'd0, sample_a_i[15:8] | sample_b_i[7:0]}
              * {8'd0, sample_b_i[15:8] | sample_a_i[7:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_mode_q <= mode_i;
      s1_a_q    <= sample_a_i;
      s1_b_q    <= sample_b_i;
      s1_prod_q <= s1_prod_d;
      s1_p1_q   <= s1_p1_d;
      s1_p2_q   <= s1_p2_d;
      s1_q5a_q  <= s1_q5a_d;
      s1_q5b_q  <= s1_q5b_d;
      s1_q6_q   <= s1_q6_d;
    end
  end

  // stage 2: second product for the mixed multiply, then select
  logic               s2_vld_q;
  logic signed [31:0] s2_t_q, s2_t_d;
  logic [31:0]        m4;
  logic signed [31:0] m4s, a_ext, b_ext;

  always_comb begin
    m4    = {16'd0, s1_p1_q} * {16'd0, s1_p2_q};
    m4s   = $signed(m4);
    a_ext = 32'(s1_a_q);
    b_ext = 32'(s1_b_q);
    unique case (s1_mode_q)
      tsbc_pkg::MODE_OR:      s2_t_d = a_ext | b_ext;
      tsbc_pkg::MODE_PROD:    s2_t_d = s1_prod_q >>> 10;
      tsbc_pkg::MODE_XOR:     s2_t_d = a_ext ^ b_ext;
      tsbc_pkg::MODE_AND:     s2_t_d = a_ext & b_ext;
      tsbc_pkg::MODE_MIX_MUL: s2_t_d = (m4s >>> 8) - tsbc_pkg::MIX_BIAS;
      tsbc_pkg::MODE_MIX_SUM: s2_t_d = $signed({16'd0, s1_q5a_q} + {16'd0, s1_q5b_q})
                                       - tsbc_pkg::MIX_BIAS;
      default:                s2_t_d = $signed({16'd0, s1_q6_q}) - tsbc_pkg::MIX_BIAS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_t_q <= s2_t_d;
    end
  end

  assign res_o.valid = s2_vld_q;
  assign res_o.value = s2_t_q;

endmodule

/* design/tsbc_fold.sv */
module tsbc_fold (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  tsbc_pkg::pipe_t pipe_i,
  output tsbc_pkg::pipe_t pipe_o
);

  logic               vld_q [tsbc_pkg::FOLD_STAGES];
  logic signed [31:0] val_q [tsbc_pkg::FOLD_STAGES];
  logic signed [31:0] val_d [tsbc_pkg::FOLD_STAGES];

  for (genvar k = 0; k < tsbc_pkg::FOLD_STAGES; k++) begin : g_stage
    logic               vld_in;
    logic signed [31:0] val_in;

    if (k == 0) begin : g_first
      assign vld_in = pipe_i.valid;
      assign val_in = pipe_i.value;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign val_in = val_q[k-1];
    end

    // the last stage may carry fewer passes
    always_comb begin
      val_d[k] = val_in;
      for (int p = 0; p < tsbc_pkg::FOLD_PER_STAGE; p++) begin
        if (k * tsbc_pkg::FOLD_PER_STAGE + p < tsbc_pkg::FOLD_PASSES) begin
          val_d[k] = tsbc_pkg::fold_pass(val_d[k]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        val_q[k] <= val_d[k];
      end
    end
  end

  assign pipe_o.valid = vld_q[tsbc_pkg::FOLD_STAGES-1];
  assign pipe_o.value = val_q[tsbc_pkg::FOLD_STAGES-1];

endmodule

/* design/two_stream_bit_combiner_folder_core.sv */
// register stages from item accept to result valid: 6 (2 combine, 4 fold)
// throughput: one item per cycle; the last fold register is the output register
// and the whole pipeline holds while a result waits on out_o.ready
// reset: pipeline valid bits clear and combine_mode returns to 0 (or);
// the config channel is always ready
module two_stream_bit_combiner_folder_core (
  input  logic clk_i,
  input  logic rst_ni,
  tsbc_cfg_if.sink   cfg_i,
  tsbc_in_if.sink    in_i,
  tsbc_out_if.source out_o
);

  tsbc_pkg::combine_mode_e mode_q;
  tsbc_pkg::pipe_t         comb_res;
  tsbc_pkg::pipe_t         fold_res;
  logic                    adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tsbc_pkg::MODE_OR;
    end else if (cfg_i.valid) begin
      mode_q <= tsbc_pkg::combine_mode_e'(cfg_i.combine_mode);
    end
  end

  // advance when the output register is empty or being drained
  assign adv        = !fold_res.valid || out_o.ready;
  assign in_i.ready = adv;

  tsbc_combine u_combine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_i.valid),
    .sample_a_i (in_i.sample_a),
    .sample_b_i (in_i.sample_b),
    .mode_i     (mode_q),
    .res_o      (comb_res)
  );

  tsbc_fold u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .pipe_i (comb_res),
    .pipe_o (fold_res)
  );

  assign out_o.valid      = fold_res.valid;
  assign out_o.sample_out = fold_res.value[15:0];

endmodule

/* dv/tsbc_checker.sv */
module tsbc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tsbc_cfg_if  cfg_i,
  tsbc_in_if   in_i,
  tsbc_out_if  out_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int                 PASSES    = 7;
  localparam logic signed [31:0] CLAMP_POS = 32'sd32767;
  localparam logic signed [31:0] CLAMP_NEG = -32'sd32767;
  localparam logic signed [31:0] MIRROR    = 32'sd65534;
  localparam logic signed [31:0] BIAS      = 32'sd32768;

  logic [2:0]         mode_q;
  logic signed [15:0] owed_samples[$];
  logic signed [15:0] want_sample;

  // mode, combine in 32-bit two's complement, then fold against +-32767
  function automatic logic signed [15:0] combine_and_fold(
    input logic [2:0]         mode,
    input logic signed [15:0] a,
    input logic signed [15:0] b
  );
    logic signed [31:0] ax, bx, a5, t;
    logic [31:0]        ha, la, hb, lb, ha5, la5, mix;
    int                 pass;
    ax  = a;
    bx  = b;
    a5  = ax + 32'sd32767;
    ha  = {24'd0, ax[15:8]};
    la  = {24'd0, ax[7:0]};
    hb  = {24'd0, bx[15:8]};
    lb  = {24'd0, bx[7:0]};
    ha5 = {24'd0, a5[15:8]};
    la5 = {24'd0, a5[7:0]};
    case (mode)
      tsbc_pkg::MODE_OR:   t = ax | bx;
      tsbc_pkg::MODE_PROD: begin
        t = ax * bx;
        t = t >>> 10;
      end
      tsbc_pkg::MODE_XOR:  t = ax ^ bx;
      tsbc_pkg::MODE_AND:  t = ax & bx;
      tsbc_pkg::MODE_MIX_MUL: begin
        // the product of byte products fits in 32 bits and is read as signed before the shift
        mix = (ha * lb) * (hb * la);
        t   = $signed(mix) >>> 8;
        t   = t - BIAS;
      end
      tsbc_pkg::MODE_MIX_SUM: begin
        mix = ha5 * la5 + hb * lb;
        t   = $signed(mix) - BIAS;
      end
      default: begin
        mix = (ha | lb) * (hb | la);
        t   = $signed(mix) - BIAS;
      end
    endcase
    for (pass = 0; pass < PASSES; pass++) begin
      if (t > CLAMP_POS) t = MIRROR - t;
      if (t < CLAMP_NEG) t = -MIRROR - t;
    end
    return t[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = tsbc_pkg::MODE_OR;
      owed_samples.delete();
      pending_o = 0;
    end else begin
      // an item accepted on this edge still sees the old mode
      if (in_i.valid && in_i.ready) begin
        owed_samples.push_back(combine_and_fold(mode_q, in_i.sample_a, in_i.sample_b));
      end
      if (out_i.valid && out_i.ready) begin
        if (owed_samples.size() == 0) begin
          $error("sample_out: no item expected, actual %0d", out_i.sample_out);
          fail_count_o++;
        end else begin
          want_sample = owed_samples.pop_front();
          if (out_i.sample_out !== want_sample) begin
            $error("sample_out: expected %0d, actual %0d", want_sample, out_i.sample_out);
            fail_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) mode_q = cfg_i.combine_mode;
      pending_o = owed_samples.size();
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;

  localparam logic [2:0] MODE_SEVEN   = 3'd7;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PHASE_ITEMS  = 100;
  localparam int         CYCLE_LIMIT  = 400000;

  logic clk_i;
  logic rst_ni;
  logic hold_req;
  int   fail_count;
  int   results_owed;
  int   cycle_count;
  int   burst_left;

  tsbc_cfg_if cfg_bus ();
  tsbc_in_if  in_bus ();
  tsbc_out_if out_bus ();

  two_stream_bit_combiner_folder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  tsbc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_bus),
    .in_i         (in_bus),
    .out_i        (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] s;
    s = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       s = 16'sh7fff;
        1:       s = 16'sh8000;
        2:       s = 16'sh0000;
        default: s = 16'shffff;
      endcase
    end
    return s;
  endfunction

  // sender works in bursts; valid stays high across items within a burst
  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_bus.valid    <= 1'b1;
    in_bus.sample_a <= a;
    in_bus.sample_b <= b;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (results_owed != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [2:0] mode);
    wait_drain();
    cfg_bus.valid        <= 1'b1;
    cfg_bus.combine_mode <= mode;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // receiver stalls in stretches of varying density, plus one long hold-off
  initial begin
    int   stall_pct;
    int   stretch_left;
    logic hold_done;
    stall_pct     = 0;
    stretch_left  = 0;
    hold_done     = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (stretch_left == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          stretch_left = $urandom_range(10, 150);
        end
        stretch_left--;
        out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    logic [2:0] mode_order[8];
    logic [2:0] mode;
    int         phase;
    int         n;
    mode_order = '{MODE_SEVEN, tsbc_pkg::MODE_OR, tsbc_pkg::MODE_MIX_SUM,
                   tsbc_pkg::MODE_PROD, tsbc_pkg::MODE_MIX_OR, tsbc_pkg::MODE_XOR,
                   tsbc_pkg::MODE_MIX_MUL, tsbc_pkg::MODE_AND};
    burst_left           = 0;
    hold_req             = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.combine_mode = tsbc_pkg::MODE_OR;
    in_bus.valid         = 1'b0;
    in_bus.sample_a      = '0;
    in_bus.sample_b      = '0;
    rst_ni               = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // field extremes under every mode, seven included
    for (n = 0; n < 8; n++) begin
      mode = 3'(n);
      write_mode(mode);
      send_pair(16'sh7fff, 16'sh8000);
      send_pair(16'shffff, 16'shffff);
      send_pair(16'sh8000, 16'sh7fff);
      stop_input();
    end

    for (phase = 0; phase < 10; phase++) begin
      mode = (phase < 8) ? mode_order[phase] : 3'($urandom_range(0, 7));
      write_mode(mode);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long output hold-off while input keeps coming, so the pipe backs up
        if (phase == 3 && n == 20) hold_req = 1'b1;
        send_pair(pick_sample(), pick_sample());
      end
      stop_input();
    end

    wait_drain();
    if (fail_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/tsbc_pkg.sv
design/tsbc_if.sv
design/tsbc_combine.sv
design/tsbc_fold.sv
design/two_stream_bit_combiner_folder_core.sv
dv/tsbc_checker.sv
dv/tb_top.sv
